/* rtl/core/signed_alu_with_flags_top_macros.svh */
// Assertion macros for the signed ALU core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SIGNED_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define SIGNED_ALU_WITH_FLAGS_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAWF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sawf assertion failed");
`define SAWF_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
        else $error("sawf forbidden condition seen");
`else
`define SAWF_ASSERT(lbl, clk, rst_n, prop)
`define SAWF_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

/* rtl/core/sawf_pkg.sv */
// Package for the signed ALU core: opcodes, widths and the pipeline record.
// No dependencies.
`timescale 1ns / 1ps
package sawf_pkg;
    localparam int WORD_W     = 32;
    localparam int DIV_STAGES = WORD_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Record that travels down the divider stages with every transaction.
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [WORD_W-1:0] alt;    // add/sub/mul result
        logic              ovf;
        logic              neg_q;  // quotient sign
        logic              a_neg;
        logic              dz;
        logic [WORD_W-1:0] dvs;    // |divisor|
        logic [WORD_W-1:0] dvd;    // |dividend|, quotient shifts in
        logic [WORD_W-1:0] rem;
    } t_pipe;
endpackage

/* rtl/core/sawf_ifs.sv */
// Channel interfaces for the signed ALU core: operand and result channels.
// Depends on sawf_pkg.
`timescale 1ns / 1ps
interface sawf_in_if
    import sawf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
    modport source (output valid, operation, operand_a, operand_b, input ready);
    modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface sawf_out_if
    import sawf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result_value;
    logic                     overflow_flag;
    logic                     zero_flag;
    logic                     div_zero_flag;
    modport source (output valid, result_value, overflow_flag, zero_flag,
                    div_zero_flag, input ready);
    modport sink   (input valid, result_value, overflow_flag, zero_flag,
                    div_zero_flag, output ready);
endinterface

/* rtl/core/signed_alu_with_flags_top.sv */
// Top level of the signed 32-bit ALU with overflow/zero/div-by-zero flags.
// Depends on sawf_pkg, sawf_ifs, sawf_front, sawf_div_stage and the macros.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   i_in     | in  | operation, operand_a, operand_b
//   o_out    | out | result_value, overflow_flag, zero_flag, div_zero_flag
//
// One transaction enters per cycle unless the pipe holds; the path is two front stages
// (add/sub/multiply, then flags and magnitudes), 32 divider stages at one
// quotient bit each, and the output register. All ops share the same depth.
// The whole pipe advances together; it holds only when the output register
// is full and not taken, so i_in.ready is low exactly then.
// Reset (i_rst_n, synchronous) clears valid bits only.
`timescale 1ns / 1ps
`include "signed_alu_with_flags_top_macros.svh"
module signed_alu_with_flags_top
    import sawf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sawf_in_if.sink           i_in,
    sawf_out_if.source        o_out
);
    logic              en;
    t_pipe             div_pipe [DIV_STAGES+1];
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] n_res;
    logic              n_ovf;
    logic              n_zero;
    logic              n_dz;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_res;
    logic              r_ovf;
    logic              r_zero;
    logic              r_dz;

    // global advance: move when the output slot is empty or being taken
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    sawf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_op    (i_in.operation),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .o_pipe  (div_pipe[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        sawf_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_pipe  (div_pipe[g]),
            .o_pipe  (div_pipe[g+1])
        );
    end

    // final select: signed quotient, divide-by-zero constants, zero flag
    always_comb begin
        quot = div_pipe[DIV_STAGES].neg_q ? (~div_pipe[DIV_STAGES].dvd + 1'b1)
                                          : div_pipe[DIV_STAGES].dvd;
        n_dz  = div_pipe[DIV_STAGES].dz;
        n_ovf = div_pipe[DIV_STAGES].ovf;
        if (div_pipe[DIV_STAGES].op == OP_DIV) begin
            if (n_dz) begin
                // +1 for negative dividend, else all ones
                n_res = div_pipe[DIV_STAGES].a_neg ? WORD_W'(1) : '1;
            end else begin
                n_res = quot;
            end
        end else begin
            n_res = div_pipe[DIV_STAGES].alt;
        end
        n_zero = !n_dz && (n_res == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_pipe[DIV_STAGES].valid;
        end
        if (en) begin
            r_res  <= n_res;
            r_ovf  <= n_ovf;
            r_zero <= n_zero;
            r_dz   <= n_dz;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_value  = r_res;
    assign o_out.overflow_flag = r_ovf;
    assign o_out.zero_flag     = r_zero;
    assign o_out.div_zero_flag = r_dz;

    // divide-by-zero results never carry zero or overflow
    `SAWF_NEVER(a_dz_flags, i_clk, i_rst_n, r_out_valid && r_dz && (r_zero || r_ovf))
    // zero flag tracks the result outside divide-by-zero
    `SAWF_ASSERT(a_zero_match, i_clk, i_rst_n, (r_out_valid && !r_dz) |-> (r_zero == (r_res == '0)))
    // an accepted transaction lands in the first front stage
    `SAWF_ASSERT(a_enter, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> u_front.r_s1_valid)
    // a held output keeps the last divider stage frozen
    `SAWF_ASSERT(a_hold, i_clk, i_rst_n, !en |=> $stable(div_pipe[DIV_STAGES].valid))
endmodule

/* rtl/core/sawf_front.sv */
// Front end: operand register with add/sub/mul, then flag and divider setup.
// Depends on sawf_pkg.
`timescale 1ns / 1ps
module sawf_front
    import sawf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [1:0]               i_op,
    input  logic signed [WORD_W-1:0] i_a,
    input  logic signed [WORD_W-1:0] i_b,
    output t_pipe                    o_pipe
);
    logic                       r_s1_valid;
    t_op                        r_s1_op;
    logic [WORD_W-1:0]          r_s1_a;
    logic [WORD_W-1:0]          r_s1_b;
    logic [WORD_W:0]            r_s1_sum;
    logic [WORD_W:0]            r_s1_dif;
    logic signed [2*WORD_W-1:0] r_s1_prod;
    t_pipe                      r_pipe;
    t_pipe                      n_pipe;

    // stage 1: sign-extended add/sub, full-width product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
        if (i_en) begin
            r_s1_op   <= t_op'(i_op);
            r_s1_a    <= i_a;
            r_s1_b    <= i_b;
            r_s1_sum  <= {i_a[WORD_W-1], i_a} + {i_b[WORD_W-1], i_b};
            r_s1_dif  <= {i_a[WORD_W-1], i_a} - {i_b[WORD_W-1], i_b};
            r_s1_prod <= i_a * i_b;
        end
    end

    // stage 2: pick result, overflow, set up magnitudes for the divider
    always_comb begin
        n_pipe       = '0;
        n_pipe.valid = r_s1_valid;
        n_pipe.op    = r_s1_op;
        case (r_s1_op)
            OP_ADD: begin
                n_pipe.alt = r_s1_sum[WORD_W-1:0];
                n_pipe.ovf = r_s1_sum[WORD_W] ^ r_s1_sum[WORD_W-1];
            end
            OP_SUB: begin
                n_pipe.alt = r_s1_dif[WORD_W-1:0];
                n_pipe.ovf = r_s1_dif[WORD_W] ^ r_s1_dif[WORD_W-1];
            end
            OP_MUL: begin
                n_pipe.alt = r_s1_prod[WORD_W-1:0];
                // high half must be a pure sign extension
                n_pipe.ovf = !((&r_s1_prod[2*WORD_W-1:WORD_W-1]) ||
                               (~|r_s1_prod[2*WORD_W-1:WORD_W-1]));
            end
            default: begin
                n_pipe.alt = '0;
                n_pipe.ovf = 1'b0;
            end
        endcase
        n_pipe.a_neg = r_s1_a[WORD_W-1];
        n_pipe.neg_q = r_s1_a[WORD_W-1] ^ r_s1_b[WORD_W-1];
        n_pipe.dz    = (r_s1_op == OP_DIV) && (r_s1_b == '0);
        n_pipe.dvd   = r_s1_a[WORD_W-1] ? (~r_s1_a + 1'b1) : r_s1_a;
        n_pipe.dvs   = r_s1_b[WORD_W-1] ? (~r_s1_b + 1'b1) : r_s1_b;
        n_pipe.rem   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
        if (i_en) begin
            r_pipe.op    <= n_pipe.op;
            r_pipe.alt   <= n_pipe.alt;
            r_pipe.ovf   <= n_pipe.ovf;
            r_pipe.neg_q <= n_pipe.neg_q;
            r_pipe.a_neg <= n_pipe.a_neg;
            r_pipe.dz    <= n_pipe.dz;
            r_pipe.dvs   <= n_pipe.dvs;
            r_pipe.dvd   <= n_pipe.dvd;
            r_pipe.rem   <= n_pipe.rem;
        end
    end

    assign o_pipe = r_pipe;
endmodule

/* rtl/core/sawf_div_stage.sv */
// One restoring-division step: one quotient bit per register stage.
// Depends on sawf_pkg.
`timescale 1ns / 1ps
module sawf_div_stage
    import sawf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_pipe,
    output t_pipe o_pipe
);
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              ge;
    t_pipe             n_pipe;
    t_pipe             r_pipe;

    always_comb begin
        shifted    = {i_pipe.rem, i_pipe.dvd[WORD_W-1]};
        diff       = shifted - {1'b0, i_pipe.dvs};
        ge         = shifted >= {1'b0, i_pipe.dvs};
        n_pipe     = i_pipe;
        n_pipe.rem = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        n_pipe.dvd = {i_pipe.dvd[WORD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
        if (i_en) begin
            r_pipe.op    <= n_pipe.op;
            r_pipe.alt   <= n_pipe.alt;
            r_pipe.ovf   <= n_pipe.ovf;
            r_pipe.neg_q <= n_pipe.neg_q;
            r_pipe.a_neg <= n_pipe.a_neg;
            r_pipe.dz    <= n_pipe.dz;
            r_pipe.dvs   <= n_pipe.dvs;
            r_pipe.dvd   <= n_pipe.dvd;
            r_pipe.rem   <= n_pipe.rem;
        end
    end

    assign o_pipe = r_pipe;
endmodule
